[design/mid_pkg.sv]
// shared types and codes for the mesh dual builder
package mid_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_LOAD  = 3'd1,
    OP_ENTRY = 3'd2,
    OP_QLINE = 3'd3,
    OP_QPNT  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP_NEG = 2'd1,
    ST_DUP_POS = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  localparam int unsigned CfgPointCount = 0;
  localparam int unsigned CfgLineCount  = 1;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic       range_err;
    logic [9:0] item_index;
    logic [9:0] first_point;
    logic [9:0] second_point;
    logic [9:0] line_ref;
    logic       line_ref_present;
    logic       reversed;
    logic       closes_surface;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic       truncated;
    logic       last;
    logic       entry_valid;
    logic       entry_reversed;
    logic [9:0] entry_line;
    logic       surface_b_valid;
    logic [9:0] surface_b;
    logic       surface_a_valid;
    logic [9:0] surface_a;
    logic [1:0] status;
  } res_t;

endpackage

[design/mid_front.sv]
// front end: accepts input beats, range checks them and queues commands
module mid_front #(
  parameter int unsigned MAX_LINES  = 1024,
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [45:0]   in_data_i,
  input  logic [10:0]   point_count_i,
  input  logic [10:0]   line_count_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output mid_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = 2;

  logic [2:0] op;
  logic [9:0] idx, p0, p1, lref;
  logic       present;
  logic [16:0] eff_lines, eff_points;
  mid_pkg::cmd_t cmd_new;

  assign op      = in_data_i[2:0];
  assign idx     = in_data_i[12:3];
  assign p0      = in_data_i[22:13];
  assign p1      = in_data_i[32:23];
  assign lref    = in_data_i[42:33];
  assign present = in_data_i[43];

  // effective counts clipped to the table sizes
  always_comb begin
    eff_lines  = (17'(line_count_i) < 17'(MAX_LINES)) ? 17'(line_count_i) : 17'(MAX_LINES);
    eff_points = (17'(point_count_i) < 17'(MAX_POINTS)) ?
                 17'(point_count_i) : 17'(MAX_POINTS);
  end

  // classify
  always_comb begin
    cmd_new = '0;
    cmd_new.op               = op;
    cmd_new.item_index       = idx;
    cmd_new.first_point      = p0;
    cmd_new.second_point     = p1;
    cmd_new.line_ref         = lref;
    cmd_new.line_ref_present = present;
    cmd_new.reversed         = in_data_i[44];
    cmd_new.closes_surface   = in_data_i[45];
    case (op)
      mid_pkg::OP_LOAD: cmd_new.range_err = (17'(idx) >= eff_lines) ||
                          (17'(p0) >= eff_points) || (17'(p1) >= eff_points);
      mid_pkg::OP_ENTRY: cmd_new.range_err = present && (17'(lref) >= eff_lines);
      mid_pkg::OP_QLINE: cmd_new.range_err = 17'(idx) >= eff_lines;
      mid_pkg::OP_QPNT:  cmd_new.range_err = 17'(idx) >= eff_points;
      default:           cmd_new.range_err = 1'b0;
    endcase
  end

  // two entry queue
  mid_pkg::cmd_t q_mem [Depth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop, valid_op;

  assign valid_op   = (op <= 3'(mid_pkg::OP_QPNT));
  assign in_ready_o = (cnt_q != 2'(Depth));
  assign push       = in_valid_i && in_ready_o && valid_op;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop        = cmd_valid_o && cmd_ready_i;
  assign cmd_o      = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue overflow");
  a_full_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(Depth)) |-> !in_ready_o) else $error("ready when full");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (cnt_q != 2'd0)) else $error("pop from empty queue");
`endif

endmodule

[design/mid_back.sv]
// back end: table memories, incidence update, queries and the point scan
module mid_back #(
  parameter int unsigned MAX_LINES    = 1024,
  parameter int unsigned MAX_SURFACES = 1024,
  parameter int unsigned MAX_DEGREE   = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  mid_pkg::cmd_t cmd_i,
  input  logic [10:0]   line_count_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output mid_pkg::res_t res_o
);

  localparam int unsigned LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned SW = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLR   = 7'b0000010,
    S_RD    = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_LAST  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // memories: line ends, users with a valid bit on top
  logic [19:0]   ends_mem [MAX_LINES];
  logic [SW:0]   neg_mem  [MAX_LINES];
  logic [SW:0]   pos_mem  [MAX_LINES];
  logic [LW-1:0] clr_q;
  logic [19:0]   ends_rd_q;
  logic [SW:0]   neg_rd_q, pos_rd_q;
  logic          clr_busy_q;

  mid_pkg::cmd_t cmd_q;
  logic [SW-1:0] surf_q;
  logic [16:0]   scan_q;
  logic [DW-1:0] n_q;
  logic          trunc_q, side_q;
  logic [16:0]   eff_lines;
  logic [LW-1:0] rd_addr;
  logic          ends_we, neg_we, pos_we, neg_clr;
  logic [SW:0]   user_wdata;

  mid_pkg::res_t res_q, res_d;
  logic          res_valid_q, res_load;
  logic [9:0]    hit_pt;

  assign eff_lines = (17'(line_count_i) < 17'(MAX_LINES)) ? 17'(line_count_i) : 17'(MAX_LINES);
  assign res_o = res_q;
  assign res_valid_o = res_valid_q;
  assign cmd_ready_o = (state_q == S_IDLE) && !clr_busy_q;

  // read address chosen by phase
  always_comb begin
    case (state_q)
      S_SCAN, S_EMIT: rd_addr = scan_q[LW-1:0];
      S_IDLE:         rd_addr = (cmd_i.op == 3'(mid_pkg::OP_ENTRY)) ?
                                cmd_i.line_ref[LW-1:0] : cmd_i.item_index[LW-1:0];
      default:        rd_addr = (cmd_q.op == 3'(mid_pkg::OP_ENTRY)) ?
                                cmd_q.line_ref[LW-1:0] : cmd_q.item_index[LW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    ends_rd_q <= ends_mem[rd_addr];
    neg_rd_q  <= neg_mem[rd_addr];
    pos_rd_q  <= pos_mem[rd_addr];
    if (ends_we) ends_mem[cmd_q.item_index[LW-1:0]] <= {cmd_q.second_point, cmd_q.first_point};
    if (neg_clr) begin
      neg_mem[clr_q] <= '0;
      pos_mem[clr_q] <= '0;
    end else begin
      if (neg_we) neg_mem[cmd_q.line_ref[LW-1:0]] <= user_wdata;
      if (pos_we) pos_mem[cmd_q.line_ref[LW-1:0]] <= user_wdata;
    end
  end

  assign user_wdata = {1'b1, surf_q};
  assign hit_pt = side_q ? ends_rd_q[19:10] : ends_rd_q[9:0];

  // control
  always_comb begin
    state_d  = state_q;
    res_d    = '0;
    res_load = 1'b0;
    ends_we  = 1'b0;
    neg_we   = 1'b0;
    pos_we   = 1'b0;
    neg_clr  = clr_busy_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !clr_busy_q) state_d = S_RD;
      end
      S_RD: state_d = S_UPD;
      S_UPD: begin
        if (!res_valid_q || res_ready_i) begin
          res_load = 1'b1;
          res_d.last = 1'b1;
          state_d = S_IDLE;
          case (cmd_q.op)
            3'(mid_pkg::OP_CLEAR): begin
              state_d = S_CLR;
            end
            3'(mid_pkg::OP_LOAD): begin
              res_d.entry_line = cmd_q.item_index;
              if (cmd_q.range_err) res_d.status = mid_pkg::ST_RANGE;
              else ends_we = 1'b1;
            end
            3'(mid_pkg::OP_ENTRY): begin
              res_d.surface_b       = 10'(surf_q);
              res_d.surface_b_valid = 1'b1;
              res_d.entry_line      = cmd_q.line_ref;
              res_d.entry_reversed  = cmd_q.reversed;
              if (cmd_q.line_ref_present) begin
                if (cmd_q.range_err) begin
                  res_d.status = mid_pkg::ST_RANGE;
                end else if (cmd_q.reversed) begin
                  if (neg_rd_q[SW]) begin
                    res_d.status = mid_pkg::ST_DUP_NEG;
                    res_d.surface_a = 10'(neg_rd_q[SW-1:0]);
                    res_d.surface_a_valid = 1'b1;
                  end else neg_we = 1'b1;
                end else begin
                  if (pos_rd_q[SW]) begin
                    res_d.status = mid_pkg::ST_DUP_POS;
                    res_d.surface_a = 10'(pos_rd_q[SW-1:0]);
                    res_d.surface_a_valid = 1'b1;
                  end else pos_we = 1'b1;
                end
              end
            end
            3'(mid_pkg::OP_QLINE): begin
              res_d.entry_line = cmd_q.item_index;
              if (cmd_q.range_err) res_d.status = mid_pkg::ST_RANGE;
              else begin
                res_d.surface_a = 10'(neg_rd_q[SW-1:0]);
                res_d.surface_a_valid = neg_rd_q[SW];
                res_d.surface_b = 10'(pos_rd_q[SW-1:0]);
                res_d.surface_b_valid = pos_rd_q[SW];
              end
            end
            default: begin
              if (cmd_q.range_err) res_d.status = mid_pkg::ST_RANGE;
              else begin
                res_load = 1'b0;
                state_d  = S_SCAN;
              end
            end
          endcase
        end
      end
      S_CLR: state_d = S_IDLE;
      S_SCAN: state_d = S_EMIT;
      S_EMIT: begin
        if (!res_valid_q || res_ready_i) begin
          if (hit_pt == cmd_q.item_index && 32'(n_q) < MAX_DEGREE
              && !(side_q && scan_q >= eff_lines)) begin
            res_load = 1'b1;
            res_d.entry_line     = 10'(scan_q);
            res_d.entry_reversed = side_q;
            res_d.entry_valid    = 1'b1;
          end
          if (side_q && scan_q + 17'd1 >= eff_lines) begin
            state_d = S_LAST;
          end else if (side_q) begin
            state_d = S_SCAN;
          end
        end
      end
      S_LAST: begin
        if (!res_valid_q || res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result register; each scan beat is held back by one beat so the final one can be marked
  mid_pkg::res_t pend_q;
  logic          pend_v_q;
  logic          res_free;
  logic          out_load;
  mid_pkg::res_t out_data, last_beat;

  assign res_free = !res_valid_q || res_ready_i;

  // choose what enters the output register
  always_comb begin
    last_beat           = pend_v_q ? pend_q : '0;
    last_beat.last      = 1'b1;
    last_beat.truncated = pend_v_q && trunc_q;
    out_load = res_load;
    out_data = res_d;
    case (state_q)
      S_EMIT: begin
        out_load = res_load && pend_v_q;
        out_data = pend_q;
      end
      S_LAST: begin
        out_load = res_free;
        out_data = last_beat;
      end
      default: out_data = res_d;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && !clr_busy_q) begin
      cmd_q <= cmd_i;
    end
    if (out_load) res_q <= out_data;
    if (state_q == S_EMIT && res_load) pend_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
      surf_q      <= '0;
      scan_q      <= '0;
      n_q         <= '0;
      trunc_q     <= 1'b0;
      side_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      // output valid
      if (out_load) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      // clearing pass over the user tables
      if (clr_busy_q) begin
        if (32'(clr_q) == MAX_LINES - 1) begin
          clr_busy_q <= 1'b0;
          clr_q      <= '0;
        end else begin
          clr_q <= clr_q + 1'b1;
        end
      end
      if (state_q == S_UPD && res_load && cmd_q.op == 3'(mid_pkg::OP_ENTRY) &&
          cmd_q.closes_surface) begin
        surf_q <= (32'(surf_q) + 1 >= MAX_SURFACES) ? '0 : surf_q + 1'b1;
      end
      if (state_q == S_UPD && cmd_q.op == 3'(mid_pkg::OP_CLEAR) && res_load) begin
        surf_q     <= '0;
        clr_busy_q <= 1'b1;
      end
      if (state_q == S_UPD && state_d == S_SCAN) begin
        scan_q <= '0; side_q <= 1'b0; n_q <= '0; trunc_q <= 1'b0; pend_v_q <= 1'b0;
      end
      if (state_q == S_EMIT && (!res_valid_q || res_ready_i)) begin
        if (hit_pt == cmd_q.item_index && !(side_q && scan_q >= eff_lines)) begin
          if (32'(n_q) < MAX_DEGREE) n_q <= n_q + 1'b1;
          else trunc_q <= 1'b1;
        end
        if (side_q) scan_q <= scan_q + 17'd1;
        side_q <= ~side_q;
        if (res_load) pend_v_q <= 1'b1;
      end
      if (state_q == S_LAST && res_free) pend_v_q <= 1'b0;
    end
  end

`ifndef SYNTH
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> res_valid_q) else $error("result dropped");
  a_no_cmd_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !cmd_ready_o) else $error("command taken while clearing");
  a_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= MAX_DEGREE) else $error("degree count overrun");
`endif

endmodule

[design/mesh_incidence_dual_builder.sv]
// top level of the mesh dual builder
// Commands are queued by a front end and run by a back end. Loads, surface entries and
// line queries pass through the back end's read and update states, and their result beat
// is registered in the update state once the output register is free. A clear returns its
// beat the same way, then the user tables are swept, one entry a cycle, as after reset,
// during which no item is taken from the queue. A point query scans the line table in the
// scan and emit states, checking the begin and then the end of each line in turn; result
// back-pressure stretches it beat by beat.
module mesh_incidence_dual_builder #(
  parameter int unsigned MAX_LINES    = 1024,
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned MAX_SURFACES = 1024,
  parameter int unsigned MAX_DEGREE   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op, item_index, first_point, second_point, line_ref, line_ref_present,
  // reversed, closes_surface, zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, surface_a, surface_a_valid, surface_b, surface_b_valid, entry_line,
  // entry_reversed, entry_valid, truncated, zero pad
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  logic [10:0]   point_count_q, line_count_q;
  logic          cmd_valid, cmd_ready;
  mid_pkg::cmd_t cmd;
  mid_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 11'd1024;
      line_count_q  <= 11'd1024;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 1'(mid_pkg::CfgPointCount)) point_count_q <= cfg_data_i;
      if (cfg_index_i == 1'(mid_pkg::CfgLineCount))  line_count_q  <= cfg_data_i;
    end
  end

  mid_front #(.MAX_LINES(MAX_LINES), .MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata[45:0]),
    .point_count_i(point_count_q), .line_count_i(line_count_q),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  mid_back #(.MAX_LINES(MAX_LINES), .MAX_SURFACES(MAX_SURFACES),
             .MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .line_count_i(line_count_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {2'b00, res.truncated, res.entry_valid, res.entry_reversed,
                         res.entry_line, res.surface_b_valid, res.surface_b,
                         res.surface_a_valid, res.surface_a, res.status};
  assign m_axis_tlast = res.last;

endmodule

[dv/mesh_incidence_dual_builder_tb.sv]
// testbench for the mesh dual builder: random and directed commands, beats checked
`timescale 1ns / 1ps

module mesh_incidence_dual_builder_tb;

  localparam int unsigned NLines   = 1024;
  localparam int unsigned NSurf    = 1024;
  localparam int unsigned NDegree  = 16;
  localparam int unsigned Settle   = 2300;
  localparam int unsigned CycLimit = 1500000;

  // one command as the stimulus sees it
  typedef struct {
    logic [2:0] op;
    logic [9:0] idx;
    logic [9:0] p0;
    logic [9:0] p1;
    logic [9:0] lref;
    logic       pres;
    logic       rev;
    logic       closes;
  } command_t;

  // dual builder model and store of beats still to come
  class dual_scoreboard;
    logic [9:0] line_begin [NLines];
    logic [9:0] line_end   [NLines];
    logic [9:0] neg_surf   [NLines];
    logic       neg_ok     [NLines];
    logic [9:0] pos_surf   [NLines];
    logic       pos_ok     [NLines];
    logic [9:0] surf_num;
    int unsigned pnt_lim;
    int unsigned n_lines;
    mid_pkg::res_t pending_beats [$];
    int errors;

    function new();
      for (int i = 0; i < NLines; i++) begin
        line_begin[i] = '0;
        line_end[i]   = '0;
      end
      wipe_users();
      pnt_lim = 1024;
      n_lines = 1024;
      errors  = 0;
    endfunction

    function void wipe_users();
      for (int i = 0; i < NLines; i++) begin
        neg_surf[i] = '0;
        neg_ok[i]   = 1'b0;
        pos_surf[i] = '0;
        pos_ok[i]   = 1'b0;
      end
      surf_num = '0;
    endfunction

    function void set_register(logic idx, logic [10:0] val);
      if (idx == 1'(mid_pkg::CfgPointCount)) pnt_lim = (val > 1024) ? 1024 : val;
      else n_lines = (val > NLines) ? NLines : val;
    endfunction

    function void push(mid_pkg::status_e st, logic [9:0] sa, logic sav, logic [9:0] sb,
                       logic sbv, logic [9:0] ln, logic rv, logic ev, logic lst, logic tr);
      mid_pkg::res_t r;
      r.status = st;
      r.surface_a = sa;
      r.surface_a_valid = sav;
      r.surface_b = sb;
      r.surface_b_valid = sbv;
      r.entry_line = ln;
      r.entry_reversed = rv;
      r.entry_valid = ev;
      r.last = lst;
      r.truncated = tr;
      pending_beats.push_back(r);
    endfunction

    // work out the beats caused by one accepted command
    function void note_command(command_t c);
      logic [9:0] cur;
      mid_pkg::status_e st;
      logic [9:0] sa;
      logic sav;
      int n;
      logic tr;
      logic [9:0] pt;
      case (c.op)
        mid_pkg::OP_CLEAR: begin
          wipe_users();
          push(mid_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 1, 0);
        end
        mid_pkg::OP_LOAD: begin
          if (c.idx >= n_lines || c.p0 >= pnt_lim || c.p1 >= pnt_lim) begin
            push(mid_pkg::ST_RANGE, 0, 0, 0, 0, c.idx, 0, 0, 1, 0);
          end else begin
            line_begin[c.idx] = c.p0;
            line_end[c.idx] = c.p1;
            push(mid_pkg::ST_OK, 0, 0, 0, 0, c.idx, 0, 0, 1, 0);
          end
        end
        mid_pkg::OP_ENTRY: begin
          cur = surf_num;
          st = mid_pkg::ST_OK;
          sa = '0;
          sav = 1'b0;
          if (c.pres) begin
            if (c.lref >= n_lines) begin
              st = mid_pkg::ST_RANGE;
            end else if (c.rev) begin
              if (neg_ok[c.lref]) begin
                st = mid_pkg::ST_DUP_NEG;
                sa = neg_surf[c.lref];
                sav = 1'b1;
              end else begin
                neg_surf[c.lref] = cur;
                neg_ok[c.lref] = 1'b1;
              end
            end else begin
              if (pos_ok[c.lref]) begin
                st = mid_pkg::ST_DUP_POS;
                sa = pos_surf[c.lref];
                sav = 1'b1;
              end else begin
                pos_surf[c.lref] = cur;
                pos_ok[c.lref] = 1'b1;
              end
            end
          end
          if (c.closes) surf_num = (cur + 1 >= NSurf) ? '0 : cur + 10'd1;
          push(st, sa, sav, cur, 1, c.lref, c.rev, 0, 1, 0);
        end
        mid_pkg::OP_QLINE: begin
          if (c.idx >= n_lines) push(mid_pkg::ST_RANGE, 0, 0, 0, 0, c.idx, 0, 0, 1, 0);
          else push(mid_pkg::ST_OK, neg_surf[c.idx], neg_ok[c.idx], pos_surf[c.idx],
                    pos_ok[c.idx], c.idx, 0, 0, 1, 0);
        end
        mid_pkg::OP_QPNT: begin
          n = 0;
          tr = 1'b0;
          if (c.idx >= pnt_lim) begin
            push(mid_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0, 0, 1, 0);
          end else begin
            // scan in line order, begin end before end end
            for (int i = 0; i < n_lines; i++) begin
              for (int s = 0; s < 2; s++) begin
                pt = s ? line_end[i] : line_begin[i];
                if (pt == c.idx) begin
                  if (n < NDegree) begin
                    push(mid_pkg::ST_OK, 0, 0, 0, 0, i[9:0], s[0], 1, 0, 0);
                    n++;
                  end else begin
                    tr = 1'b1;
                  end
                end
              end
            end
            if (n == 0) begin
              push(mid_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 1, 0);
            end else begin
              pending_beats[$].last = 1'b1;
              pending_beats[$].truncated = tr;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_beat(logic [39:0] d, logic lst);
      mid_pkg::res_t e;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: data %h last %b", d, lst);
        errors++;
        return;
      end
      e = pending_beats.pop_front();
      compare("status", e.status, d[1:0]);
      compare("surface_a", e.surface_a, d[11:2]);
      compare("surface_a_valid", e.surface_a_valid, d[12]);
      compare("surface_b", e.surface_b, d[22:13]);
      compare("surface_b_valid", e.surface_b_valid, d[23]);
      compare("entry_line", e.entry_line, d[33:24]);
      compare("entry_reversed", e.entry_reversed, d[34]);
      compare("entry_valid", e.entry_valid, d[35]);
      compare("truncated", e.truncated, d[36]);
      compare("last", e.last, lst);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [10:0] cfg_data_i;

  dual_scoreboard sb;
  bit gaps_on;
  bit stalls_on;
  int stall_left;
  int unsigned cycles;
  bit loaded [NLines];

  mesh_incidence_dual_builder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("FAIL mesh_incidence_dual_builder");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_axis_tready <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(1, 16);
    end
  end

  // result beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tlast);
  end

  // drive one command beat, with an optional gap first
  task automatic send(command_t c);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, c.closes, c.rev, c.pres, c.lref, c.p1, c.p0, c.idx, c.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(c);
    if (c.op == mid_pkg::OP_LOAD && c.idx < sb.n_lines && c.p0 < sb.pnt_lim &&
        c.p1 < sb.pnt_lim)
      loaded[c.idx] = 1'b1;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(logic idx, logic [10:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic command_t mk(logic [2:0] op, logic [9:0] idx, logic [9:0] p0,
                                 logic [9:0] p1, logic [9:0] lref, logic pres,
                                 logic rev, logic closes);
    command_t c;
    c.op = op; c.idx = idx; c.p0 = p0; c.p1 = p1;
    c.lref = lref; c.pres = pres; c.rev = rev; c.closes = closes;
    return c;
  endfunction

  function automatic bit all_loaded();
    for (int i = 0; i < sb.n_lines; i++) if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // point within range, mostly a few low points so queries find ends
  function automatic logic [9:0] pick_point();
    int unsigned hi;
    hi = (sb.pnt_lim < 8) ? sb.pnt_lim - 1 : 7;
    if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, sb.pnt_lim - 1));
    return 10'($urandom_range(0, hi));
  endfunction

  function automatic logic [9:0] pick_line();
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    return 10'($urandom_range(0, sb.n_lines + 1));
  endfunction

  // random command with random filler in unused fields
  function automatic command_t random_command();
    command_t c;
    int unsigned r;
    c = mk(3'($urandom), 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
           1'($urandom), 1'($urandom), 1'($urandom));
    r = $urandom_range(0, 99);
    if (r < 2) begin
      c.op = mid_pkg::OP_CLEAR;
    end else if (r < 22) begin
      c.op = mid_pkg::OP_LOAD;
      c.idx = pick_line();
      c.p0 = pick_point();
      c.p1 = pick_point();
    end else if (r < 65 || (r < 92 && r >= 78 && !all_loaded())) begin
      c.op = mid_pkg::OP_ENTRY;
      c.lref = pick_line();
      c.pres = ($urandom_range(0, 9) != 0);
    end else if (r < 78) begin
      c.op = mid_pkg::OP_QLINE;
      c.idx = pick_line();
    end else if (r < 92) begin
      c.op = mid_pkg::OP_QPNT;
      c.idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) : pick_point();
    end else begin
      c.op = 3'($urandom_range(5, 7));
    end
    return c;
  endfunction

  task automatic load_all();
    for (int i = 0; i < sb.n_lines; i++)
      send(mk(mid_pkg::OP_LOAD, i[9:0], pick_point(), pick_point(), 10'($urandom),
              1'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send(random_command());
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < NLines; i++) loaded[i] = 1'b0;
    cycles = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    stall_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    cfg_valid_i = 1'b0;
    cfg_index_i = 1'b0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: defaults, extremes, conflicts, unknown ops
    send(mk(mid_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_LOAD, 0, 0, 10'h3ff, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_LOAD, 10'h3ff, 10'h3ff, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 0, 1, 0, 0));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 0, 1, 0, 0));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 0, 1, 1, 1));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 0, 1, 1, 0));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 10'h155, 0, 1, 0));
    send(mk(mid_pkg::OP_ENTRY, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 1, 1, 1));
    send(mk(mid_pkg::OP_QLINE, 0, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_QLINE, 10'h3ff, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_QLINE, 5, 0, 0, 0, 0, 0, 0));
    send(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
    send(mk(3'd6, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 1, 1, 1));
    send(mk(3'd7, 0, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_CLEAR, 10'h3ff, 10'h3ff, 10'h3ff, 10'h3ff, 1, 1, 1));
    send(mk(mid_pkg::OP_QLINE, 0, 0, 0, 0, 0, 0, 0));

    // closing entries back to back
    gaps_on = 1'b0;
    for (int i = 0; i < 3; i++) send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 0, 0, 0, 1));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 7, 1, 0, 0));
    send(mk(mid_pkg::OP_QLINE, 7, 0, 0, 0, 0, 0, 0));
    gaps_on = 1'b1;

    // smallest mesh: range errors and a point with both ends
    write_reg(1'(mid_pkg::CfgPointCount), 11'd1);
    write_reg(1'(mid_pkg::CfgLineCount), 11'd1);
    send(mk(mid_pkg::OP_LOAD, 1, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_LOAD, 0, 1, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_QPNT, 0, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_QPNT, 1, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_QLINE, 1, 0, 0, 0, 0, 0, 0));
    send(mk(mid_pkg::OP_ENTRY, 0, 0, 0, 1, 1, 0, 1));

    // dense mesh: few points
    write_reg(1'(mid_pkg::CfgPointCount), 11'd4);
    write_reg(1'(mid_pkg::CfgLineCount), 11'd12);
    load_all();
    send(mk(mid_pkg::OP_QPNT, 0, 0, 0, 0, 0, 0, 0));
    random_run(30);

    // sparser mesh
    write_reg(1'(mid_pkg::CfgPointCount), 11'd700);
    write_reg(1'(mid_pkg::CfgLineCount), 11'd40);
    load_all();
    random_run(30);

    // full size, point queries only once every line is loaded
    write_reg(1'(mid_pkg::CfgPointCount), 11'd1024);
    write_reg(1'(mid_pkg::CfgLineCount), 11'd1024);
    random_run(25);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    random_run(15);

    wait_idle();
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("PASS mesh_incidence_dual_builder");
    end else begin
      $display("FAIL mesh_incidence_dual_builder");
    end
    $finish;
  end

endmodule
